### design/sha256_pkg.sv
// SHA-256 constants and round functions shared by the hasher and its checker.
// Holds the initial hash values, the round constant table and the sigma functions.
// Depends on nothing.
package sha256_pkg;

    localparam int unsigned ChainWords  = 8;
    localparam int unsigned WindowWords = 16;
    localparam int unsigned Rounds      = 64;

    localparam logic [5:0] LengthPos = 6'd56;
    localparam logic [7:0] PadMarker = 8'h80;
    localparam logic [2:0] LastIndex = 3'd7;

    localparam logic [31:0] InitHash [ChainWords] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // rotate right by a constant amount
    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### design/sha256_stream_hasher.sv
// Streaming SHA-256 hasher: byte absorb, padding sequencer and one shared round unit.
// Depends on sha256_pkg.
//
// Usage: the input channel (in_valid / in_stall) carries one request per item:
// operation 0 absorbs message_byte, operation 1 finishes the message. The output
// channel (out_valid / out_stall) then carries the eight digest words, H0 first,
// with word_index on every word and last_word on the eighth.
// An absorbed byte is written into the message window; every 64th byte adds one block
// compression (64 rounds, one per cycle, plus the chaining add).
// While a block compresses, in_stall holds off further bytes, set by the single round unit.
// A finish writes the padding bytes (up to 64, the 0x80 marker first), the length
// field, then runs one or two compressions and delivers the eight digest words.
// in_stall is high whenever the block is busy or a digest is still being delivered.
// A stalled digest word holds; the block waits until all eight words are taken,
// then reinitializes for the next message.
// Reset clears the chaining words to the initial hash, the byte count and the
// position; the block leaves reset idle, ready to accept a request.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  message_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    // what follows a block compression
    typedef enum logic [1:0] {
        CTX_ABSORB,
        CTX_PAD,
        CTX_DIGEST
    } ctx_t;

    state_t      state_reg, state_next;
    ctx_t        ctx_reg, ctx_next;
    logic        long_reg, long_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] chain_reg [sha256_pkg::ChainWords];
    logic [31:0] chain_next [sha256_pkg::ChainWords];
    logic [31:0] work_reg [sha256_pkg::ChainWords];
    logic [31:0] work_next [sha256_pkg::ChainWords];
    logic [31:0] w_reg [sha256_pkg::WindowWords];
    logic [31:0] w_next [sha256_pkg::WindowWords];

    logic        in_take;
    logic [31:0] t1, t2, sched_word;

    assign in_take = in_valid && (state_reg == ST_IDLE);

    // round unit: one SHA-256 round and one schedule word per cycle
    always_comb
    begin
        t1 = work_reg[7] + sha256_pkg::big_sigma1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + sha256_pkg::RoundK[round_reg] + w_reg[0];
        t2 = sha256_pkg::big_sigma0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
        sched_word = w_reg[0] + sha256_pkg::small_sigma0(w_reg[1]) + w_reg[9]
                   + sha256_pkg::small_sigma1(w_reg[14]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        long_next  = long_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        w_next     = w_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    pos_next = pos_reg + 6'd1;
                    if (operation == 1'b0)
                    begin
                        w_next[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] = message_byte;
                        bits_next = bits_reg + 64'd8;
                        ctx_next  = CTX_ABSORB;
                    end
                    else
                    begin
                        w_next[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] =
                            sha256_pkg::PadMarker;
                        long_next  = (pos_reg >= sha256_pkg::LengthPos);
                        ctx_next   = CTX_PAD;
                        state_next = ST_PAD;
                    end
                    // block full: compress
                    if (pos_reg == 6'd63)
                    begin
                        long_next  = 1'b0;
                        round_next = '0;
                        work_next  = chain_reg;
                        state_next = ST_ROUND;
                    end
                end
            end

            ST_PAD:
            begin
                if (pos_reg == sha256_pkg::LengthPos && !long_reg)
                begin
                    // length field, big-endian
                    w_next[14] = bits_reg[63:32];
                    w_next[15] = bits_reg[31:0];
                    ctx_next   = CTX_DIGEST;
                    round_next = '0;
                    work_next  = chain_reg;
                    state_next = ST_ROUND;
                end
                else
                begin
                    w_next[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] = 8'h00;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        long_next  = 1'b0;
                        ctx_next   = CTX_PAD;
                        round_next = '0;
                        work_next  = chain_reg;
                        state_next = ST_ROUND;
                    end
                end
            end

            ST_ROUND:
            begin
                work_next[0] = t1 + t2;
                work_next[1] = work_reg[0];
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3] + t1;
                work_next[5] = work_reg[4];
                work_next[6] = work_reg[5];
                work_next[7] = work_reg[6];
                for (int i = 0; i < sha256_pkg::WindowWords - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[sha256_pkg::WindowWords - 1] = sched_word;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int i = 0; i < sha256_pkg::ChainWords; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                case (ctx_reg)
                    CTX_ABSORB: state_next = ST_IDLE;
                    CTX_PAD:    state_next = ST_PAD;
                    CTX_DIGEST:
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                    default:    state_next = ST_IDLE;
                endcase
            end

            ST_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::LastIndex)
                    begin
                        chain_next = sha256_pkg::InitHash;
                        bits_next  = '0;
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctx_reg   <= CTX_ABSORB;
            long_reg  <= 1'b0;
            pos_reg   <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            chain_reg <= sha256_pkg::InitHash;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            long_reg  <= long_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    // window and working words carry no reset
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        w_reg    <= w_next;
    end

    // ports
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha256_pkg::LastIndex);

endmodule

### design/sha256_stream_hasher_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound into every sha256_stream_hasher instance.
// Depends on sha256_pkg and sha256_stream_hasher.
module sha256_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // no new request is taken while a digest is being delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted during digest delivery");

    // a stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled digest word changed");

    // words of one digest come back to back in index order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=>
            out_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest word sequence broken");

    // last_word marks exactly the final index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == sha256_pkg::LastIndex)))
        else $error("last_word out of place");

    // an absorbed byte never starts a digest
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !operation |=> !out_valid)
        else $error("digest after absorb request");

endmodule

bind sha256_stream_hasher sha256_checker u_sha256_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
